// ===== rtl/rotary_encoder_debounce_decoder_defines.svh =====
// Assertion macros for the rotary encoder debounce decoder.
// No dependencies; included by the top-level file, which carries concurrent checks.
`ifndef ROTARY_ENCODER_DEBOUNCE_DECODER_DEFINES_SVH
`define ROTARY_ENCODER_DEBOUNCE_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define RED_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define RED_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define RED_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define RED_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/red_pkg.sv =====
// Package for the rotary encoder debounce decoder: request/result types,
// step codes, register map and width constants. No dependencies.
`default_nettype none

package red_pkg;

  // Field widths fixed by the interface
  localparam int unsigned POSITION_VALUE_BITS = 16;
  localparam int unsigned STEP_EVENT_BITS     = 2;
  localparam int unsigned DEBOUNCE_BITS       = 16;

  // Position counter width: default and widest supported
  localparam int unsigned POSITION_BITS_DEFAULT = 16;
  localparam int unsigned POSITION_BITS_MAX     = 32;

  // APB register map
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned REG_INDEX_LSB = 2;
  localparam logic REG_DEBOUNCE_TICKS   = 1'b0;
  localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_TICKS_RESET = DEBOUNCE_BITS'(1);

  // Step event codes
  localparam logic [STEP_EVENT_BITS-1:0] STEP_NONE = 2'd0;
  localparam logic [STEP_EVENT_BITS-1:0] STEP_UP   = 2'd1;
  localparam logic [STEP_EVENT_BITS-1:0] STEP_DOWN = 2'd2;

  // Decoder mode, one-hot
  typedef enum logic [2:0] {
    MODE_ARMED     = 3'b001,
    MODE_DEBOUNCE  = 3'b010,
    MODE_WAIT_DATA = 3'b100
  } mode_t;

  // One pin sample
  typedef struct packed {
    logic clock_level;
    logic data_level;
  } sample_t;

  // One result
  typedef struct packed {
    logic signed [POSITION_VALUE_BITS-1:0] position_value;
    logic [STEP_EVENT_BITS-1:0]            step_event;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/rotary_encoder_debounce_decoder.sv =====
// Rotary encoder debounce decoder, top level.
// Depends on red_pkg and rotary_encoder_debounce_decoder_defines.svh.
`default_nettype none
`include "rotary_encoder_debounce_decoder_defines.svh"

// Takes one sample of the encoder clock and data pins per request and returns
// one result per request: the detent position after that sample and whether
// it stepped up or down on it. The edge detection, debounce counter and
// position update sit between the pin sample and a single result register,
// so a new request is taken every cycle while the result register is empty
// or being read. out_valid rises in the cycle after acceptance.
// debounce_ticks (APB offset 0, reset 1, zero behaves as one) is the debounce
// count loaded on a clock falling edge and counted down by accepted samples
// before the step is confirmed; changing it only affects the next count load.
module rotary_encoder_debounce_decoder #(
  parameter int unsigned POSITION_BITS = red_pkg::POSITION_BITS_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // sample channel
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire red_pkg::sample_t                     in_item,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output red_pkg::result_t                          out_item,
  // APB configuration port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [red_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  wire logic [red_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [red_pkg::APB_DATA_BITS-1:0]         prdata,
  output logic                                      pready
);

  import red_pkg::*;

  // State
  mode_t                    mode, mode_next;
  logic [DEBOUNCE_BITS-1:0] debounce_count, debounce_count_next;
  logic                     captured_data, captured_data_next;
  logic                     prev_clock;
  logic                     prev_data;
  logic [POSITION_BITS-1:0] position_count, position_count_next;
  logic [STEP_EVENT_BITS-1:0] step_next;
  logic [DEBOUNCE_BITS-1:0] debounce_ticks;

  logic in_fire;
  logic clk_fall;
  logic dat_fall;
  logic [POSITION_BITS_MAX-1:0] position_ext;
  logic cfg_write;

  // APB: always ready, single register at index 0
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_TICKS_RESET;
    end else if (cfg_write && (paddr[REG_INDEX_LSB] == REG_DEBOUNCE_TICKS)) begin
      debounce_ticks <= pwdata[DEBOUNCE_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[REG_INDEX_LSB] == REG_DEBOUNCE_TICKS) begin
      prdata = APB_DATA_BITS'(debounce_ticks);
    end
  end

  // Handshake: result register frees as it is read
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Falling edges against the previous sample
  assign clk_fall = prev_clock && !in_item.clock_level;
  assign dat_fall = prev_data && !in_item.data_level;

  // Decoder next state
  always_comb begin
    mode_next           = mode;
    debounce_count_next = debounce_count;
    captured_data_next  = captured_data;
    position_count_next = position_count;
    step_next           = STEP_NONE;
    case (mode)
      MODE_DEBOUNCE: begin
        if (dat_fall) begin
          // cancel wins over expiry
          mode_next = MODE_ARMED;
        end else if (debounce_count <= DEBOUNCE_BITS'(1)) begin
          debounce_count_next = '0;
          if (!in_item.clock_level && (in_item.data_level == captured_data)) begin
            if (captured_data) begin
              position_count_next = position_count + POSITION_BITS'(1);
              step_next           = STEP_UP;
            end else begin
              position_count_next = position_count - POSITION_BITS'(1);
              step_next           = STEP_DOWN;
            end
            mode_next = MODE_WAIT_DATA;
          end else begin
            mode_next = MODE_ARMED;
          end
        end else begin
          debounce_count_next = debounce_count - DEBOUNCE_BITS'(1);
        end
      end
      MODE_WAIT_DATA: begin
        if (dat_fall) begin
          mode_next = MODE_ARMED;
        end
      end
      default: begin
        mode_next = MODE_ARMED;
        if (clk_fall) begin
          captured_data_next  = in_item.data_level;
          debounce_count_next = debounce_ticks;
          mode_next           = MODE_DEBOUNCE;
        end
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_ARMED;
      debounce_count <= '0;
      captured_data  <= 1'b0;
      prev_clock     <= 1'b1;
      prev_data      <= 1'b1;
      position_count <= '0;
    end else if (in_fire) begin
      mode           <= mode_next;
      debounce_count <= debounce_count_next;
      captured_data  <= captured_data_next;
      prev_clock     <= in_item.clock_level;
      prev_data      <= in_item.data_level;
      position_count <= position_count_next;
    end
  end

  // Result register: low bits of the position, zero-extended if narrower
  assign position_ext = POSITION_BITS_MAX'(position_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item.position_value <= position_ext[POSITION_VALUE_BITS-1:0];
      out_item.step_event     <= step_next;
    end
  end

  // Checks
  `RED_ASSERT_NEXT(a_step_only_from_debounce, clk, rst,
    in_fire && (mode != MODE_DEBOUNCE), out_item.step_event == STEP_NONE)
  `RED_ASSERT_NEXT(a_position_held_outside_debounce, clk, rst,
    in_fire && (mode != MODE_DEBOUNCE), $stable(position_count))
  `RED_ASSERT_NEXT(a_wait_holds_without_data_fall, clk, rst,
    in_fire && (mode == MODE_WAIT_DATA) && !dat_fall, mode == MODE_WAIT_DATA)
  `RED_ASSERT_IMPLIES(a_no_stall_when_result_taken, clk, rst,
    out_ready, in_ready)

endmodule

`default_nettype wire

// ===== dv/red_checker.sv =====
// Result checker for the rotary encoder debounce decoder: watches the sample,
// result and APB channels, predicts every result and compares it.
// Depends on red_pkg only.
`default_nettype none

module red_checker
  import red_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic                     in_ready,
  input  wire sample_t                  in_item,
  input  wire logic                     out_valid,
  input  wire logic                     out_ready,
  input  wire result_t                  out_item,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  input  wire logic                     pready,
  output int unsigned                   fail_count,
  output int unsigned                   results_owed
);

  localparam int unsigned MAX_REPORTS = 10;

  // Shadow of the decoder state and its one register
  mode_t                    mode_q;
  logic [DEBOUNCE_BITS-1:0] ticks_cfg;
  logic [DEBOUNCE_BITS-1:0] count_q;
  logic                     captured_q;
  logic                     prev_clk_q;
  logic                     prev_dat_q;
  logic [POSITION_BITS-1:0] position_q;

  // Results owed for accepted requests, oldest first
  result_t due_results[$];

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] decoder mismatch: %s", $time, msg);
    end
  endtask

  // Advance the shadow decoder by one pin sample and give the result it owes
  task automatic advance_decoder(input sample_t s, output result_t r);
    logic                       clk_fall;
    logic                       dat_fall;
    logic [STEP_EVENT_BITS-1:0] step;
    clk_fall = prev_clk_q && !s.clock_level;
    dat_fall = prev_dat_q && !s.data_level;
    step     = STEP_NONE;
    case (mode_q)
      MODE_DEBOUNCE: begin
        // a data fall cancels, even on the expiry tick
        if (dat_fall) begin
          mode_q = MODE_ARMED;
        end else if (count_q <= DEBOUNCE_BITS'(1)) begin
          count_q = '0;
          if (!s.clock_level && s.data_level == captured_q) begin
            if (captured_q) begin
              position_q = position_q + 1'b1;
              step       = STEP_UP;
            end else begin
              position_q = position_q - 1'b1;
              step       = STEP_DOWN;
            end
            mode_q = MODE_WAIT_DATA;
          end else begin
            mode_q = MODE_ARMED;
          end
        end else begin
          count_q = count_q - 1'b1;
        end
      end
      MODE_WAIT_DATA: begin
        if (dat_fall) mode_q = MODE_ARMED;
      end
      default: begin
        mode_q = MODE_ARMED;
        if (clk_fall) begin
          captured_q = s.data_level;
          count_q    = ticks_cfg;
          mode_q     = MODE_DEBOUNCE;
        end
      end
    endcase
    prev_clk_q       = s.clock_level;
    prev_dat_q       = s.data_level;
    r.position_value = POSITION_VALUE_BITS'(position_q);
    r.step_event     = step;
  endtask

  // Watch all three ports at each rising edge
  always @(posedge clk) begin : watch
    result_t predicted;
    result_t wanted;
    if (rst) begin
      mode_q     = MODE_ARMED;
      ticks_cfg  = DEBOUNCE_TICKS_RESET;
      count_q    = '0;
      captured_q = 1'b0;
      prev_clk_q = 1'b1;
      prev_dat_q = 1'b1;
      position_q = '0;
      fail_count = 0;
      due_results.delete();
    end else begin
      // register write; other indexes hold nothing
      if (psel && penable && pwrite && pready &&
          paddr[APB_ADDR_BITS-1:REG_INDEX_LSB] == REG_DEBOUNCE_TICKS) begin
        ticks_cfg = pwdata[DEBOUNCE_BITS-1:0];
      end
      // result leaving the block
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          log_failure($sformatf("result with nothing owed: position %0d step %0d",
                                out_item.position_value, out_item.step_event));
        end else begin
          wanted = due_results.pop_front();
          if (out_item.position_value !== wanted.position_value ||
              out_item.step_event !== wanted.step_event) begin
            log_failure($sformatf("position %0d (expected %0d), step %0d (expected %0d)",
                                  out_item.position_value, wanted.position_value,
                                  out_item.step_event, wanted.step_event));
          end
        end
      end
      // request entering the block
      if (in_valid && in_ready) begin
        advance_decoder(in_item, predicted);
        due_results.push_back(predicted);
      end
    end
    results_owed = due_results.size();
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Stimulus and verdict for the rotary encoder debounce decoder.
// Depends on red_pkg, the block itself and red_checker.
`default_nettype none

module tb_top;
  import red_pkg::*;

  localparam int          CLK_HALF        = 6;
  localparam int unsigned CYCLE_LIMIT     = 1_500_000;
  localparam int unsigned LONG_HOLD       = 120;
  localparam int unsigned DRAIN           = 8;
  localparam int unsigned RANDOM_ITEMS    = 1100;
  localparam int unsigned PHASES          = 5;
  localparam int unsigned LONG_COUNT_HOLD = 20;
  localparam logic [APB_ADDR_BITS-1:0] ADDR_DEBOUNCE_TICKS =
    APB_ADDR_BITS'(REG_DEBOUNCE_TICKS) << REG_INDEX_LSB;
  // next index up has no register behind it
  localparam logic [APB_ADDR_BITS-1:0] ADDR_UNMAPPED =
    ADDR_DEBOUNCE_TICKS + (APB_ADDR_BITS'(1) << REG_INDEX_LSB);

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  sample_t                  in_item   = '1;
  logic                     out_ready = 1'b0;
  logic                     psel      = 1'b0;
  logic                     penable   = 1'b0;
  logic                     pwrite    = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr     = '0;
  logic [APB_DATA_BITS-1:0] pwdata    = '0;
  logic                     in_ready;
  logic                     out_valid;
  result_t                  out_item;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  int unsigned              fail_count;
  int unsigned              results_owed;
  int unsigned              items_sent = 0;
  int unsigned              cycles     = 0;
  logic [DEBOUNCE_BITS-1:0] ticks_now  = DEBOUNCE_TICKS_RESET;
  bit                       quiet      = 1'b0;
  bit                       hold_req   = 1'b0;
  bit                       hold_done  = 1'b0;

  rotary_encoder_debounce_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  red_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_item     (out_item),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always #CLK_HALF clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    int unsigned held;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        for (held = 1; held < LONG_HOLD; held++) @(negedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(1, 14);
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // One pin-sample request; called and returns at a falling edge
  task automatic send_sample(input logic clk_lvl, input logic dat_lvl);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{clock_level: clk_lvl, data_level: dat_lvl};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic hold_levels(input logic clk_lvl, input logic dat_lvl, input int unsigned n);
    repeat (n) send_sample(clk_lvl, dat_lvl);
  endtask

  // Register write once the block has drained
  task automatic write_reg(input logic [APB_ADDR_BITS-1:0] addr,
                           input logic [APB_DATA_BITS-1:0] value);
    in_valid <= 1'b0;
    wait (results_owed == 0);
    repeat (2) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_debounce(input logic [APB_DATA_BITS-1:0] value);
    write_reg(ADDR_DEBOUNCE_TICKS, value);
    ticks_now = value[DEBOUNCE_BITS-1:0];
  endtask

  // One detent: clock falls with data giving the direction, held for a while,
  // possibly with contact bounce, then data falls and the clock goes high
  task automatic detent(input logic up, input int unsigned hold, input bit bouncy);
    int unsigned k;
    hold_levels(1'b1, 1'b1, $urandom_range(1, 3));
    send_sample(1'b0, up);
    for (k = 0; k < hold; k++) begin
      if (bouncy && $urandom_range(0, 7) == 0) begin
        send_sample(1'($urandom), 1'($urandom));
      end else begin
        send_sample(1'b0, up);
      end
    end
    if (!up) send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned target;
    int unsigned eff;
    int unsigned hold;
    int unsigned n;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: clean up and down steps at the reset debounce of one tick
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b1);
    // clock fall while waiting for the data fall is ignored
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b0);
    // step down, position back to zero
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);
    // data fall on the expiry tick cancels the check
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b0);
    // clock back high at the check: no step
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b1);
    // data moved away from the captured level at the check: no step
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b1);
    // data fall while armed is ignored
    send_sample(1'b1, 1'b0);

    // Zero debounce behaves as one; unmapped index is ignored
    set_debounce('0);
    write_reg(ADDR_UNMAPPED, '1);
    detent(1'b1, 1, 1'b0);
    detent(1'b0, 1, 1'b0);

    // Change the register mid-count: the running count is not affected
    set_debounce(6);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    set_debounce(2);
    hold_levels(1'b0, 1'b1, 6);
    send_sample(1'b0, 1'b0);
    detent(1'b1, 2, 1'b0);

    // Longest debounce, upper data bits set; a data fall cancels the long count
    set_debounce('1);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    hold_levels(1'b0, 1'b1, LONG_COUNT_HOLD);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);

    // Random phases: mostly detents with random timing and bounce, some noise
    for (phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 4))
        0:       set_debounce(0);
        1:       set_debounce(1);
        default: set_debounce($urandom_range(2, 8));
      endcase
      eff = (ticks_now == 0) ? 1 : 32'(ticks_now);
      if (phase == 1) hold_req = 1'b1;
      if (phase == PHASES - 1) quiet = 1'b1;
      target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) begin
        if ($urandom_range(0, 4) == 0) begin
          n = $urandom_range(1, 4);
          repeat (n) send_sample(1'($urandom), 1'($urandom));
        end else begin
          if ($urandom_range(0, 3) == 0) hold = $urandom_range(0, eff);
          else hold = $urandom_range(eff, eff + 3);
          detent(1'($urandom), hold, $urandom_range(0, 3) == 0);
        end
      end
    end

    // Drain and verdict
    in_valid <= 1'b0;
    wait (results_owed == 0);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== rotary_encoder_debounce_decoder.f =====
+incdir+rtl
rtl/red_pkg.sv
rtl/rotary_encoder_debounce_decoder.sv
dv/red_checker.sv
dv/tb_top.sv
